@@ design/bdpe_pkg.sv @@
// Shared types and constants for the button debounce and press event block.
package bdpe_pkg;

  localparam logic [2:0]  DebMax      = 3'd4;
  localparam logic [2:0]  DebStart    = 3'd2;
  localparam logic [1:0]  LongCount   = 2'd2;
  localparam logic [7:0]  PeriodReset = 8'd150;
  localparam logic [31:0] SeqStart    = 32'd1;
  localparam int unsigned RawKeys     = 8;

  localparam logic CfgInvertMask  = 1'b0;
  localparam logic CfgPressPeriod = 1'b1;

  typedef enum logic [2:0] {
    EvPress   = 3'd0,
    EvRelease = 3'd1,
    EvShort   = 3'd2,
    EvLong    = 3'd3,
    EvRepeat  = 3'd4
  } event_e;

  typedef struct packed {
    logic [2:0] deb;
    logic       stable;
    logic [1:0] periods;
    logic [7:0] ticks;
    logic       running;
  } key_state_t;

  typedef struct packed {
    logic [1:0] count;
    event_e     first;
    event_e     second;
    logic       press;
  } key_events_t;

  typedef struct packed {
    logic [2:0]  key_index;
    event_e      event_type;
    logic [31:0] sequence_number;
  } event_t;

endpackage

@@ design/bdpe_in_if.sv @@
// Request channel that carries one tick of raw button bits.
interface bdpe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_buttons;

  modport source (output valid, output raw_buttons, input ready);
  modport sink (input valid, input raw_buttons, output ready);
endinterface

@@ design/bdpe_out_if.sv @@
// Request channel that carries one key event.
interface bdpe_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  key_index;
  logic [2:0]  event_type;
  logic [31:0] sequence_number;
  logic        last_event;

  modport source (output valid, output key_index, output event_type,
                  output sequence_number, output last_event, input ready);
  modport sink (input valid, input key_index, input event_type,
                input sequence_number, input last_event, output ready);
endinterface

@@ design/bdpe_key_unit.sv @@
// Shared per-key step: press timer advance followed by the debounce update.
module bdpe_key_unit import bdpe_pkg::*; (
  input  key_state_t  state_i,
  input  logic        level_i,
  input  logic [7:0]  period_i,
  output key_state_t  state_o,
  output key_events_t events_o
);

  key_state_t  st;
  key_events_t ev;
  logic [7:0]  tick_inc;
  logic [1:0]  per_inc;
  logic        fire;
  logic        settled;
  logic        change;

  always_comb begin
    st = state_i;
    ev.count = 2'd0;
    ev.first = EvPress;
    ev.second = EvPress;
    ev.press = 1'b0;
    tick_inc = st.ticks + 8'd1;
    per_inc = st.periods + 2'd1;
    fire = st.running && !(tick_inc < period_i);

    if (st.running) begin
      if (fire) begin
        st.ticks = 8'd0;
        if (per_inc == LongCount) begin
          st.periods = per_inc;
          ev.first = EvLong;
          ev.count = 2'd1;
        end else if (per_inc > LongCount) begin
          st.periods = LongCount;
          ev.first = EvRepeat;
          ev.count = 2'd1;
        end else begin
          st.periods = per_inc;
        end
      end else begin
        st.ticks = tick_inc;
      end
    end

    if (level_i) begin
      if (st.deb < DebMax) st.deb = st.deb + 3'd1;
    end else begin
      if (st.deb != 3'd0) st.deb = st.deb - 3'd1;
    end

    settled = (st.deb == 3'd0) || (st.deb == DebMax);
    change = settled && (st.stable != level_i);

    if (change) begin
      st.stable = level_i;
      st.ticks = 8'd0;
      if (level_i) begin
        st.running = 1'b1;
        ev.press = 1'b1;
        if (ev.count == 2'd0) ev.first = EvPress;
        else ev.second = EvPress;
        ev.count = ev.count + 2'd1;
      end else begin
        st.running = 1'b0;
        if (st.periods < LongCount) begin
          if (ev.count == 2'd0) ev.first = EvShort;
          else ev.second = EvShort;
          ev.count = ev.count + 2'd1;
        end
        st.periods = 2'd0;
        if (ev.count == 2'd0) ev.first = EvRelease;
        else ev.second = EvRelease;
        ev.count = ev.count + 2'd1;
      end
    end
  end

  assign state_o = st;
  assign events_o = ev;

endmodule

@@ design/button_debounce_press_events.sv @@
// Top level of the button debounce block with press, short, long and repeat events.
//
// A tick of raw button bits arrives on tick_i. The block then walks the keys
// in index order, one key per cycle while it finds no events, through a shared
// key unit that advances the press timer and then the debounce counter. Each
// event found is put on event_o, one request per event, with last_event set on
// the final event of the tick.
// tick_i is not ready from acceptance until the final event of the tick has
// moved to the output register.
// A key's events are registered in ev_q, then held in hold_q, and then loaded
// into out_q, which drives event_o.
// One event is held back in a staging register so that last_event is known;
// when event_o stalls, the walk pauses at the next event and resumes when the
// output register frees up. A new tick may be accepted while the final event
// still waits at event_o.
// Reset clears the debounce counters to the middle value, all keys to released,
// all timers to stopped, the sequence counter to one and the register defaults.
// Configuration writes are taken at any time and must only be made while idle.
module button_debounce_press_events import bdpe_pkg::*; #(
  parameter int unsigned NUM_KEYS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [7:0]       cfg_data_i,
  bdpe_in_if.sink          tick_i,
  bdpe_out_if.source       event_o
);

  localparam int unsigned KeyW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [KeyW-1:0] LastKey = KeyW'(NUM_KEYS - 1);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StKey   = 2'd1;
  localparam logic [1:0] StEmit  = 2'd2;
  localparam logic [1:0] StFlush = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [7:0]      raw_q;
  logic [7:0]      invert_q;
  logic [7:0]      period_q;
  key_state_t      keys_q [NUM_KEYS];
  logic [31:0]     seq_q [NUM_KEYS];
  logic [31:0]     next_seq_q;
  key_events_t     ev_q;
  logic [31:0]     ev_seq_q;
  logic [2:0]      ev_key_q;
  logic            ev_idx_q;
  logic            hold_valid_q;
  event_t          hold_q;
  logic            out_valid_q;
  event_t          out_q;
  logic            out_last_q;

  logic [4:0]      key_wide;
  logic            level;
  key_state_t      unit_state;
  key_events_t     unit_ev;
  logic [31:0]     key_seq;
  logic            out_load;
  logic            hold_move;
  logic            ev_done;
  event_e          cur_type;
  logic            out_push;
  logic            accept;

  assign key_wide = 5'(key_q);
  assign level = (key_wide < 5'(RawKeys)) ?
                 (raw_q[key_wide[2:0]] ^ invert_q[key_wide[2:0]]) : 1'b0;

  bdpe_key_unit u_key_unit (
    .state_i  (keys_q[key_q]),
    .level_i  (level),
    .period_i (period_q),
    .state_o  (unit_state),
    .events_o (unit_ev)
  );

  assign key_seq   = unit_ev.press ? next_seq_q : seq_q[key_q];
  assign out_load  = !out_valid_q || event_o.ready;
  assign hold_move = !hold_valid_q || out_load;
  assign ev_done   = ((2'(ev_idx_q) + 2'd1) == ev_q.count);
  assign cur_type  = ev_idx_q ? ev_q.second : ev_q.first;
  assign out_push  = hold_valid_q && out_load &&
                     ((state_q == StEmit) || (state_q == StFlush));
  assign accept    = tick_i.valid && tick_i.ready;

  assign tick_i.ready = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    key_d = key_q;
    unique case (state_q)
      StIdle: begin
        if (tick_i.valid) begin
          state_d = StKey;
          key_d = '0;
        end
      end
      StKey: begin
        if (unit_ev.count != 2'd0) begin
          state_d = StEmit;
        end else if (key_q == LastKey) begin
          state_d = StFlush;
        end else begin
          key_d = key_q + KeyW'(1);
        end
      end
      StEmit: begin
        if (hold_move && ev_done) begin
          if (key_q == LastKey) begin
            state_d = StFlush;
          end else begin
            state_d = StKey;
            key_d = key_q + KeyW'(1);
          end
        end
      end
      StFlush: begin
        if (!hold_valid_q || out_load) state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      key_q <= '0;
      invert_q <= 8'd0;
      period_q <= PeriodReset;
      next_seq_q <= SeqStart;
      ev_idx_q <= 1'b0;
      hold_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        keys_q[i] <= '{deb: DebStart, stable: 1'b0, periods: 2'd0,
                       ticks: 8'd0, running: 1'b0};
      end
    end else begin
      state_q <= state_d;
      key_q <= key_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgInvertMask:  invert_q <= cfg_data_i;
          CfgPressPeriod: period_q <= cfg_data_i;
        endcase
      end
      if (state_q == StKey) begin
        keys_q[key_q] <= unit_state;
        ev_idx_q <= 1'b0;
        if (unit_ev.press) next_seq_q <= next_seq_q + 32'd1;
      end
      if (state_q == StEmit && hold_move) begin
        ev_idx_q <= 1'b1;
        hold_valid_q <= 1'b1;
      end
      if (state_q == StFlush && hold_valid_q && out_load) begin
        hold_valid_q <= 1'b0;
      end
      if (out_push) begin
        out_valid_q <= 1'b1;
      end else if (event_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) raw_q <= tick_i.raw_buttons;
    if (state_q == StKey) begin
      if (unit_ev.press) seq_q[key_q] <= next_seq_q;
      ev_q <= unit_ev;
      ev_seq_q <= key_seq;
      ev_key_q <= key_wide[2:0];
    end
    if (state_q == StEmit && hold_move) begin
      hold_q <= '{key_index: ev_key_q, event_type: cur_type, sequence_number: ev_seq_q};
    end
    if (out_push) begin
      out_q <= hold_q;
      out_last_q <= (state_q == StFlush);
    end
  end

  assign event_o.valid           = out_valid_q;
  assign event_o.key_index       = out_q.key_index;
  assign event_o.event_type      = out_q.event_type;
  assign event_o.sequence_number = out_q.sequence_number;
  assign event_o.last_event      = out_last_q;

endmodule

@@ design/bdpe_checker.sv @@
// Port-level assertions for the button debounce block and their binding.
module bdpe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  key_index_i,
  input logic [2:0]  event_type_i,
  input logic [31:0] sequence_number_i,
  input logic        last_event_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(key_index_i) &&
      $stable(event_type_i) && $stable(sequence_number_i) && $stable(last_event_i))
    else $error("event changed while stalled");

  a_busy_after_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("tick accepted while previous tick in progress");

  a_mid_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_event_i |-> !in_ready_i)
    else $error("new tick possible before final event of tick");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("event shown during reset");

endmodule

bind button_debounce_press_events bdpe_checker u_bdpe_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (tick_i.valid),
  .in_ready_i        (tick_i.ready),
  .out_valid_i       (event_o.valid),
  .out_ready_i       (event_o.ready),
  .key_index_i       (event_o.key_index),
  .event_type_i      (event_o.event_type),
  .sequence_number_i (event_o.sequence_number),
  .last_event_i      (event_o.last_event)
);

@@ tb/button_debounce_press_events_test.sv @@
`timescale 1ns / 1ps
// Testbench that sends raw button ticks to the debounce block and checks each key event.
module button_debounce_press_events_test import bdpe_pkg::*; ();

  localparam int unsigned KeyCount = 8;
  localparam int unsigned MaxGap = 10;
  localparam int unsigned SettleCycles = 48;
  localparam int unsigned RandomTicks = 420;
  localparam int unsigned RandomPhases = 6;

  typedef struct {
    logic [2:0]  key;
    event_e      kind;
    logic [31:0] seq;
    logic        last;
  } key_event_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_index_i;
  logic [7:0] cfg_data_i;

  bdpe_in_if  tick_if ();
  bdpe_out_if event_if ();

  button_debounce_press_events dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .tick_i      (tick_if),
    .event_o     (event_if)
  );

  logic [7:0]  invert_mask;
  logic [7:0]  press_period;
  logic [2:0]  deb_count [KeyCount];
  logic        key_down [KeyCount];
  logic [1:0]  period_count [KeyCount];
  logic [7:0]  timer_count [KeyCount];
  logic        timer_on [KeyCount];
  logic [31:0] key_seq [KeyCount];
  logic [31:0] next_seq;

  key_event_t  key_event_q [$];
  int unsigned ticks_sent;
  int unsigned events_seen;
  int unsigned mismatches;
  int unsigned kind_seen [5];
  bit          no_stall;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("button_debounce_press_events_test NOT OK");
    $finish;
  end

  function automatic void reset_key_model();
    invert_mask = '0;
    press_period = PeriodReset;
    for (int k = 0; k < KeyCount; k++) begin
      deb_count[k] = DebStart;
      key_down[k] = 1'b0;
      period_count[k] = '0;
      timer_count[k] = '0;
      timer_on[k] = 1'b0;
      key_seq[k] = '0;
    end
    next_seq = SeqStart;
  endfunction

  function automatic key_event_t key_event(input int k, input event_e kind);
    key_event_t ev;
    ev.key = k[2:0];
    ev.kind = kind;
    ev.seq = key_seq[k];
    ev.last = 1'b0;
    return ev;
  endfunction

  function automatic void debounce_tick(input logic [7:0] raw);
    key_event_t found [$];
    logic       level;
    for (int k = 0; k < KeyCount; k++) begin
      if (timer_on[k]) begin
        timer_count[k] = timer_count[k] + 8'd1;
        if (timer_count[k] >= press_period) begin
          timer_count[k] = '0;
          period_count[k] = period_count[k] + 2'd1;
          if (period_count[k] == LongCount) begin
            found.push_back(key_event(k, EvLong));
          end else if (period_count[k] > LongCount) begin
            period_count[k] = LongCount;
            found.push_back(key_event(k, EvRepeat));
          end
        end
      end
      level = raw[k] ^ invert_mask[k];
      if (level && deb_count[k] < DebMax) begin
        deb_count[k] = deb_count[k] + 3'd1;
      end else if (!level && deb_count[k] != 3'd0) begin
        deb_count[k] = deb_count[k] - 3'd1;
      end
      if ((deb_count[k] == 3'd0 || deb_count[k] == DebMax) && key_down[k] != level) begin
        key_down[k] = level;
        if (level) begin
          key_seq[k] = next_seq;
          next_seq = next_seq + 32'd1;
          timer_count[k] = '0;
          timer_on[k] = 1'b1;
          found.push_back(key_event(k, EvPress));
        end else begin
          timer_on[k] = 1'b0;
          timer_count[k] = '0;
          if (period_count[k] < LongCount) begin
            found.push_back(key_event(k, EvShort));
          end
          period_count[k] = '0;
          found.push_back(key_event(k, EvRelease));
        end
      end
    end
    foreach (found[i]) begin
      found[i].last = (i == found.size() - 1);
      key_event_q.push_back(found[i]);
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  task automatic check_key_event();
    key_event_t want;
    events_seen++;
    if (key_event_q.size() == 0) begin
      note_mismatch($sformatf({"expected no event, ",
                               "got key %0d type %0d seq %0d last %0d"},
                              event_if.key_index, event_if.event_type,
                              event_if.sequence_number, event_if.last_event));
      return;
    end
    want = key_event_q.pop_front();
    if (event_if.key_index !== want.key || event_if.event_type !== want.kind ||
        event_if.sequence_number !== want.seq || event_if.last_event !== want.last) begin
      note_mismatch($sformatf({"event %0d: expected key %0d type %0d seq %0d last %0d, ",
                               "got key %0d type %0d seq %0d last %0d"},
                              events_seen, want.key, want.kind, want.seq, want.last,
                              event_if.key_index, event_if.event_type,
                              event_if.sequence_number, event_if.last_event));
    end else begin
      kind_seen[int'(want.kind)]++;
    end
  endtask

  initial begin
    int unsigned stall;
    event_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = no_stall ? 0 : $urandom_range(0, MaxGap);
      if (stall != 0) begin
        event_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      event_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!event_if.valid) @(posedge clk_i);
      check_key_event();
    end
  end

  task automatic send_tick(input logic [7:0] raw);
    int unsigned gap;
    gap = no_stall ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      tick_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tick_if.valid <= 1'b1;
    tick_if.raw_buttons <= raw;
    @(posedge clk_i);
    while (!tick_if.ready) @(posedge clk_i);
    ticks_sent++;
    debounce_tick(raw);
  endtask

  task automatic wait_idle();
    tick_if.valid <= 1'b0;
    while (key_event_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic index, input logic [7:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (index == CfgInvertMask) begin
      invert_mask = data;
    end else begin
      press_period = data;
    end
    @(posedge clk_i);
  endtask

  // All keys press and release together under the reset settings.
  task automatic test_reset_defaults();
    repeat (2) send_tick(8'hFF);
    repeat (4) send_tick(8'h00);
  endtask

  // Every key is active low and the timer fires every tick.
  task automatic test_inverted_fast_timer();
    wait_idle();
    write_reg(CfgInvertMask, 8'hFF);
    write_reg(CfgPressPeriod, 8'd1);
    repeat (7) send_tick(8'h00);
    repeat (4) send_tick(8'hFF);
  endtask

  // A slow timer is cut to a zero period while keys are held.
  task automatic test_period_change();
    wait_idle();
    write_reg(CfgInvertMask, 8'h00);
    write_reg(CfgPressPeriod, 8'd255);
    repeat (6) send_tick(8'h5A);
    wait_idle();
    write_reg(CfgPressPeriod, 8'd0);
    repeat (3) send_tick(8'h5A);
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned hold;
    logic [7:0]  pattern;
    pattern = '0;
    for (int phase = 0; phase < RandomPhases; phase++) begin
      wait_idle();
      no_stall = (phase == 2);
      write_reg(CfgInvertMask, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CfgPressPeriod, 8'($urandom_range(1, 255)));
      end else begin
        write_reg(CfgPressPeriod, 8'($urandom_range(1, 6)));
      end
      sent = 0;
      while (sent < RandomTicks / RandomPhases) begin
        if ($urandom_range(0, 9) < 8) begin
          pattern = 8'($urandom_range(0, 255));
          hold = $urandom_range(2, 12);
          repeat (hold) send_tick(pattern);
          sent += hold;
        end else begin
          send_tick(pattern ^ (8'd1 << $urandom_range(0, 7)));
          sent++;
        end
      end
    end
    no_stall = 1'b0;
  endtask

  initial begin
    cfg_we_i <= 1'b0;
    cfg_index_i <= CfgInvertMask;
    cfg_data_i <= '0;
    tick_if.valid <= 1'b0;
    tick_if.raw_buttons <= '0;
    rst_ni <= 1'b0;
    no_stall = 1'b0;
    reset_key_model();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_inverted_fast_timer();
    test_period_change();
    test_random_traffic();
    wait_idle();

    $display("Sent %0d ticks through several mask and period settings, checked %0d events.",
             ticks_sent, events_seen);
    $display("Matched press %0d, release %0d, short %0d, long %0d, repeat %0d.",
             kind_seen[int'(EvPress)], kind_seen[int'(EvRelease)],
             kind_seen[int'(EvShort)], kind_seen[int'(EvLong)],
             kind_seen[int'(EvRepeat)]);
    if (mismatches == 0) begin
      $display("button_debounce_press_events_test OK");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("button_debounce_press_events_test NOT OK");
    end
    $finish;
  end

endmodule
